>>> hw/rtl/tep_pkg.sv
// Shared types and constants for the terminal escape parser.
`timescale 1ns / 1ps

package tep_pkg;

  localparam logic [7:0] CH_ESC      = 8'h1B;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_QUESTION = 8'h3F;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;
  localparam logic [7:0] CH_SET      = 8'h68;
  localparam logic [7:0] CH_RESET    = 8'h6C;

  localparam logic [15:0] PASTE_CODE = 16'd2004;
  localparam logic [15:0] PARAM_MAX  = 16'hFFFF;

  localparam int QUEUE_DEPTH = 2;
  localparam int OUT_BITS    = 34;
  localparam int OUT_BYTES_W = 40;

  typedef enum logic [3:0] {
    CLS_ESC,
    CLS_CR,
    CLS_LF,
    CLS_LBRACKET,
    CLS_QUESTION,
    CLS_DIGIT,
    CLS_SET,
    CLS_RESET,
    CLS_OTHER
  } char_class_t;

  typedef struct packed {
    char_class_t cls;
    logic [7:0]  ch;
  } item_t;

  typedef struct packed {
    logic       paste_mode;
    logic [6:0] cursor_col_out;
    logic [4:0] cursor_row_out;
    logic [7:0] write_char;
    logic [6:0] write_col;
    logic [4:0] write_row;
    logic       write_valid;
  } result_t;

endpackage

>>> hw/rtl/terminal_escape_parser.sv
// Top level of the terminal escape parser.
`timescale 1ns / 1ps
// Usage:
//   s_axis carries one character byte per request in s_axis_tdata[7:0].
//   m_axis returns one result per character: an optional grid write
//   (valid, row, column, byte), the cursor position after the byte and
//   the bracketed paste flag.
// Path: each byte passes the classifier register, a queue entry and the
//   result register before m_axis_tvalid rises.
// Throughput: one character per cycle while m_axis_tready keeps up; parser
//   state updates in the execution stage, which sets the rate.
// Stalls: the classifier and executor are split by a two-entry queue and
//   the result sits in an output register, so input keeps flowing while
//   a result waits; when m_axis_tready stays low the queue fills and
//   s_axis_tready drops.
// Reset: rst (synchronous) returns the parser to ground, clears the private
//   flag, parameter, paste flag and cursor, and empties all stages.
// ROWS and COLS set the grid; row and column outputs carry the low 5 and
//   7 bits of the position.

module terminal_escape_parser #(
  parameter int ROWS = 32,
  parameter int COLS = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_char
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] write_valid, [5:1] write_row, [12:6] write_col, [20:13] write_char,
  // [25:21] cursor_row_out, [32:26] cursor_col_out, [33] paste_mode, [39:34] zero
  output logic [39:0] m_axis_tdata
);

  logic             front_valid;
  logic             front_ready;
  tep_pkg::item_t   front_item;
  logic             q_valid;
  logic             q_ready;
  tep_pkg::item_t   q_item;
  tep_pkg::result_t result;

  tep_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .item_valid    (front_valid),
    .item_ready    (front_ready),
    .item          (front_item)
  );

  tep_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_item  (front_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  tep_back #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (q_valid),
    .item_ready (q_ready),
    .item       (q_item),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_data   (result)
  );

  assign m_axis_tdata = {(tep_pkg::OUT_BYTES_W - tep_pkg::OUT_BITS)'(0), result};

endmodule

>>> hw/rtl/tep_front.sv
// Input stage: accepts character requests and classifies each byte.
`timescale 1ns / 1ps

module tep_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_axis_tvalid,
  output logic           s_axis_tready,
  input  logic [7:0]     s_axis_tdata,   // [7:0] in_char
  output logic           item_valid,
  input  logic           item_ready,
  output tep_pkg::item_t item
);

  tep_pkg::char_class_t cls_next;
  logic                 take;

  always_comb begin
    if (s_axis_tdata == tep_pkg::CH_ESC) begin
      cls_next = tep_pkg::CLS_ESC;
    end else if (s_axis_tdata == tep_pkg::CH_CR) begin
      cls_next = tep_pkg::CLS_CR;
    end else if (s_axis_tdata == tep_pkg::CH_LF) begin
      cls_next = tep_pkg::CLS_LF;
    end else if (s_axis_tdata == tep_pkg::CH_LBRACKET) begin
      cls_next = tep_pkg::CLS_LBRACKET;
    end else if (s_axis_tdata == tep_pkg::CH_QUESTION) begin
      cls_next = tep_pkg::CLS_QUESTION;
    end else if (s_axis_tdata >= tep_pkg::CH_ZERO && s_axis_tdata <= tep_pkg::CH_NINE) begin
      cls_next = tep_pkg::CLS_DIGIT;
    end else if (s_axis_tdata == tep_pkg::CH_SET) begin
      cls_next = tep_pkg::CLS_SET;
    end else if (s_axis_tdata == tep_pkg::CH_RESET) begin
      cls_next = tep_pkg::CLS_RESET;
    end else begin
      cls_next = tep_pkg::CLS_OTHER;
    end
  end

  assign s_axis_tready = !item_valid || item_ready;
  assign take          = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        item_valid <= s_axis_tvalid;
      end
      if (take) begin
        item.cls <= cls_next;
        item.ch  <= s_axis_tdata;
      end
    end
  end

endmodule

>>> hw/rtl/tep_queue.sv
// Two-entry queue between the classifier and the execution stage.
`timescale 1ns / 1ps

module tep_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  tep_pkg::item_t push_item,
  output logic           pop_valid,
  input  logic           pop_ready,
  output tep_pkg::item_t pop_item
);

  localparam int PTR_W = $clog2(tep_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(tep_pkg::QUEUE_DEPTH + 1);

  tep_pkg::item_t entries [tep_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign push_ready = count < CNT_W'(tep_pkg::QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_item   = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(tep_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(tep_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(tep_pkg::QUEUE_DEPTH))
    else $error("queue count above depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> !pop)
    else $error("pop from empty queue");

endmodule

>>> hw/rtl/tep_back.sv
// Execution stage: escape parser state, cursor tracking and result register.
`timescale 1ns / 1ps

module tep_back #(
  parameter int ROWS = 32,
  parameter int COLS = 128
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  tep_pkg::item_t   item,
  output logic             out_valid,
  input  logic             out_ready,
  output tep_pkg::result_t out_data
);

  localparam int ROW_W = $clog2(ROWS);
  localparam int COL_W = $clog2(COLS);
  localparam int ROW_X = ROW_W + 5;
  localparam int COL_X = COL_W + 7;

  typedef enum logic [1:0] {
    PH_GROUND,
    PH_ESCAPE,
    PH_CSI
  } phase_t;

  phase_t           phase, phase_next;
  logic             priv, priv_next;
  logic [15:0]      param, param_next;
  logic             paste, paste_next;
  logic [ROW_W-1:0] row, row_next;
  logic [COL_W-1:0] col, col_next;
  logic             wv;
  logic [19:0]      digit_sum;
  logic [ROW_X-1:0] row_wide, row_next_wide;
  logic [COL_X-1:0] col_wide, col_next_wide;
  tep_pkg::result_t res_next;
  logic             pop;

  assign item_ready = !out_valid || out_ready;
  assign pop        = item_valid && item_ready;

  // param * 10 + digit, at most 20 bits
  assign digit_sum = {1'b0, param, 3'b000} + {3'b000, param, 1'b0} + 20'(item.ch[3:0]);

  always_comb begin
    phase_next = phase;
    priv_next  = priv;
    param_next = param;
    paste_next = paste;
    row_next   = row;
    col_next   = col;
    wv         = 1'b0;
    case (phase)
      PH_ESCAPE: begin
        if (item.cls == tep_pkg::CLS_LBRACKET) begin
          phase_next = PH_CSI;
          priv_next  = 1'b0;
          param_next = '0;
        end else begin
          phase_next = PH_GROUND;
        end
      end
      PH_CSI: begin
        case (item.cls)
          tep_pkg::CLS_QUESTION: priv_next = 1'b1;
          tep_pkg::CLS_DIGIT: begin
            param_next = (digit_sum > {4'b0000, tep_pkg::PARAM_MAX}) ? tep_pkg::PARAM_MAX
                                                                   : digit_sum[15:0];
          end
          tep_pkg::CLS_SET, tep_pkg::CLS_RESET: begin
            if (priv && param == tep_pkg::PASTE_CODE) begin
              paste_next = (item.cls == tep_pkg::CLS_SET);
            end
            phase_next = PH_GROUND;
          end
          default: phase_next = PH_CSI;
        endcase
      end
      default: begin
        phase_next = PH_GROUND;
        case (item.cls)
          tep_pkg::CLS_ESC: phase_next = PH_ESCAPE;
          tep_pkg::CLS_CR:  col_next = '0;
          tep_pkg::CLS_LF: begin
            if (row < ROW_W'(ROWS - 1)) begin
              row_next = row + 1'b1;
            end
          end
          default: begin
            wv = 1'b1;
            if (col < COL_W'(COLS - 1)) begin
              col_next = col + 1'b1;
            end else if (row < ROW_W'(ROWS - 1)) begin
              row_next = row + 1'b1;
              col_next = '0;
            end
          end
        endcase
      end
    endcase
  end

  assign row_wide      = ROW_X'(row);
  assign col_wide      = COL_X'(col);
  assign row_next_wide = ROW_X'(row_next);
  assign col_next_wide = COL_X'(col_next);

  always_comb begin
    res_next.write_valid    = wv;
    res_next.write_row      = wv ? row_wide[4:0] : 5'd0;
    res_next.write_col      = wv ? col_wide[6:0] : 7'd0;
    res_next.write_char     = wv ? item.ch : 8'd0;
    res_next.cursor_row_out = row_next_wide[4:0];
    res_next.cursor_col_out = col_next_wide[6:0];
    res_next.paste_mode     = paste_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_GROUND;
      priv      <= 1'b0;
      param     <= '0;
      paste     <= 1'b0;
      row       <= '0;
      col       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (item_ready) begin
        out_valid <= item_valid;
      end
      if (pop) begin
        phase    <= phase_next;
        priv     <= priv_next;
        param    <= param_next;
        paste    <= paste_next;
        row      <= row_next;
        col      <= col_next;
        out_data <= res_next;
      end
    end
  end

  a_cursor_bound: assert property (@(posedge clk) disable iff (rst)
    row <= ROW_W'(ROWS - 1) && col <= COL_W'(COLS - 1))
    else $error("cursor outside grid");

  a_write_from_ground: assert property (@(posedge clk) disable iff (rst)
    (pop && phase == PH_GROUND && item.cls == tep_pkg::CLS_OTHER) |=>
      (out_valid && out_data.write_valid))
    else $error("printable byte in ground gave no grid write");

  a_paste_cause: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && paste != $past(paste)) |->
      ($past(pop) && $past(phase) == PH_CSI &&
       ($past(item.cls) == tep_pkg::CLS_SET || $past(item.cls) == tep_pkg::CLS_RESET)))
    else $error("paste flag changed outside a mode request");

endmodule

>>> sim/tb_terminal_escape_parser.sv
// Testbench for the terminal escape parser: random character streams, self-checking predictor.
`timescale 1ns / 1ps

module tb_terminal_escape_parser;

  localparam int ROWS = 32;
  localparam int COLS = 128;
  localparam int IDLE_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 1900;
  localparam int SQUEEZE_AT = 400;
  localparam int SQUEEZE_CYCLES = 250;

  typedef enum logic [1:0] {
    ST_GROUND,
    ST_ESCAPE,
    ST_CSI
  } parse_state_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;

  logic [7:0]        char_feed[$];
  tep_pkg::result_t  expected_results[$];
  int                errors = 0;
  int                results_seen = 0;
  logic              in_taken = 1'b0;
  int                idle_cycles = 0;

  // predictor state
  parse_state_t esc_state = ST_GROUND;
  logic         priv = 1'b0;
  logic [15:0]  param = '0;
  logic         paste = 1'b0;
  logic [4:0]   row = '0;
  logic [6:0]   col = '0;

  // sender and receiver pacing
  int tx_gap = 0;
  int tx_quiet = 0;
  int rx_hold = 0;
  int rx_quiet = 0;
  logic squeeze_done = 1'b0;

  terminal_escape_parser #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic tep_pkg::result_t predict_step(input logic [7:0] c);
    tep_pkg::result_t r;
    int unsigned acc;
    r = '0;
    case (esc_state)
      ST_ESCAPE: begin
        if (c == tep_pkg::CH_LBRACKET) begin
          esc_state = ST_CSI;
          priv = 1'b0;
          param = '0;
        end else begin
          esc_state = ST_GROUND;
        end
      end
      ST_CSI: begin
        if (c == tep_pkg::CH_QUESTION) begin
          priv = 1'b1;
        end else if (c >= tep_pkg::CH_ZERO && c <= tep_pkg::CH_NINE) begin
          acc = param * 10 + 32'(c - tep_pkg::CH_ZERO);
          param = (acc > tep_pkg::PARAM_MAX) ? tep_pkg::PARAM_MAX : 16'(acc);
        end else if (c == tep_pkg::CH_SET || c == tep_pkg::CH_RESET) begin
          if (priv && param == tep_pkg::PASTE_CODE) paste = (c == tep_pkg::CH_SET);
          esc_state = ST_GROUND;
        end
      end
      default: begin
        esc_state = ST_GROUND;
        if (c == tep_pkg::CH_ESC) begin
          esc_state = ST_ESCAPE;
        end else if (c == tep_pkg::CH_CR) begin
          col = '0;
        end else if (c == tep_pkg::CH_LF) begin
          if (row < ROWS - 1) row = row + 5'd1;
        end else begin
          r.write_valid = 1'b1;
          r.write_row = row;
          r.write_col = col;
          r.write_char = c;
          if (col < COLS - 1) begin
            col = col + 7'd1;
          end else if (row < ROWS - 1) begin
            row = row + 5'd1;
            col = '0;
          end
        end
      end
    endcase
    r.cursor_row_out = row;
    r.cursor_col_out = col;
    r.paste_mode = paste;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got_v, input int exp_v);
    errors++;
    if (errors <= 40)
      $display("%0t mismatch %s: got %0d expected %0d (result %0d)",
               $time, what, got_v, exp_v, results_seen);
  endtask

  // ground-mode text with no ESC, CR or LF bytes
  task automatic add_text(input int n);
    logic [7:0] c;
    for (int i = 0; i < n; i++) begin
      c = 8'($urandom_range(0, 255));
      if (c == tep_pkg::CH_ESC || c == tep_pkg::CH_CR || c == tep_pkg::CH_LF) c = c ^ 8'h40;
      char_feed.push_back(c);
    end
  endtask

  task automatic add_number(input int unsigned n);
    string s;
    s = $sformatf("%0d", n);
    for (int i = 0; i < s.len(); i++) char_feed.push_back(s[i]);
  endtask

  task automatic add_mode_seq(input bit with_priv, input int unsigned n, input bit set_it);
    char_feed.push_back(tep_pkg::CH_ESC);
    char_feed.push_back(tep_pkg::CH_LBRACKET);
    if (with_priv) char_feed.push_back(tep_pkg::CH_QUESTION);
    if ($urandom_range(0, 9) == 0) char_feed.push_back(tep_pkg::CH_ZERO);
    add_number(n);
    if ($urandom_range(0, 9) == 0) char_feed.push_back(8'($urandom_range(0, 255)));
    char_feed.push_back(set_it ? tep_pkg::CH_SET : tep_pkg::CH_RESET);
  endtask

  task automatic add_random_segment();
    int sel;
    int unsigned n;
    logic [7:0] c;
    sel = $urandom_range(0, 99);
    if (sel < 30) begin
      add_text($urandom_range(1, 12));
    end else if (sel < 35) begin
      add_text($urandom_range(100, 140));
    end else if (sel < 45) begin
      char_feed.push_back(tep_pkg::CH_CR);
      if ($urandom_range(0, 1)) char_feed.push_back(tep_pkg::CH_LF);
    end else if (sel < 55) begin
      repeat ($urandom_range(1, 6)) char_feed.push_back(tep_pkg::CH_LF);
    end else if (sel < 80) begin
      n = $urandom_range(0, 99);
      if (n < 70) n = 32'(tep_pkg::PASTE_CODE);
      else if (n < 80) n = $urandom_range(0, 9999);
      else if (n < 90) n = $urandom_range(60000, 99999);
      else n = $urandom;
      add_mode_seq($urandom_range(0, 4) != 0, n, 1'($urandom_range(0, 1)));
    end else if (sel < 90) begin
      char_feed.push_back(tep_pkg::CH_ESC);
      if ($urandom_range(0, 1)) begin
        c = 8'($urandom_range(0, 255));
        if (c == tep_pkg::CH_LBRACKET) c = tep_pkg::CH_ESC;
        char_feed.push_back(c);
      end else begin
        char_feed.push_back(tep_pkg::CH_LBRACKET);
        repeat ($urandom_range(1, 8)) char_feed.push_back(8'($urandom_range(0, 255)));
      end
    end else begin
      repeat ($urandom_range(1, 8)) char_feed.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    // directed: byte extremes, CR, LF, aborted escape, ESC inside CSI,
    // paste on, parameter saturation with a mode byte but no private flag
    char_feed.push_back(8'h00);
    char_feed.push_back(8'hFF);
    char_feed.push_back(tep_pkg::CH_CR);
    char_feed.push_back(tep_pkg::CH_LF);
    char_feed.push_back(tep_pkg::CH_ESC);
    char_feed.push_back("x");
    char_feed.push_back(tep_pkg::CH_ESC);
    char_feed.push_back(tep_pkg::CH_LBRACKET);
    char_feed.push_back(tep_pkg::CH_QUESTION);
    char_feed.push_back("2");
    char_feed.push_back("0");
    char_feed.push_back(tep_pkg::CH_ESC);
    char_feed.push_back("0");
    char_feed.push_back("4");
    char_feed.push_back(tep_pkg::CH_SET);
    add_mode_seq(1'b0, 999999, 1'b0);
    while (char_feed.size() < RANDOM_ITEMS + 25) add_random_segment();

    repeat (2) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    do @(posedge clk); while (char_feed.size() != 0 || s_axis_tvalid);
    while (expected_results.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  always @(negedge clk) begin : drive_requests
    int r;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (s_axis_tvalid && !in_taken) begin
      // hold the request until accepted
    end else if (tx_gap != 0) begin
      s_axis_tvalid <= 1'b0;
      tx_gap <= tx_gap - 1;
    end else if (char_feed.size() != 0) begin
      s_axis_tdata <= char_feed.pop_front();
      s_axis_tvalid <= 1'b1;
      r = $urandom_range(0, 99);
      if (tx_quiet != 0) begin
        tx_quiet <= tx_quiet - 1;
      end else if (r < 3) begin
        tx_quiet <= $urandom_range(30, 100);
      end else if (r < 30) begin
        tx_gap <= $urandom_range(1, 3);
      end else if (r < 33) begin
        tx_gap <= $urandom_range(10, 60);
      end
    end else begin
      s_axis_tvalid <= 1'b0;
    end
  end

  always @(negedge clk) begin : drive_ready
    int r;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (rx_hold != 0) begin
      m_axis_tready <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else if (!squeeze_done && results_seen >= SQUEEZE_AT) begin
      m_axis_tready <= 1'b0;
      rx_hold <= SQUEEZE_CYCLES;
      squeeze_done <= 1'b1;
    end else if (rx_quiet != 0) begin
      m_axis_tready <= 1'b1;
      rx_quiet <= rx_quiet - 1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        m_axis_tready <= 1'b1;
        rx_quiet <= $urandom_range(40, 120);
      end else if (r < 20) begin
        m_axis_tready <= 1'b0;
        rx_hold <= $urandom_range(0, 2);
      end else if (r < 23) begin
        m_axis_tready <= 1'b0;
        rx_hold <= $urandom_range(8, 40);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_results
    tep_pkg::result_t got;
    tep_pkg::result_t exp_r;
    if (rst) begin
      in_taken <= 1'b0;
      esc_state = ST_GROUND;
      priv = 1'b0;
      param = '0;
      paste = 1'b0;
      row = '0;
      col = '0;
    end else begin
      in_taken <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready)
        expected_results.push_back(predict_step(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen <= results_seen + 1;
        got = m_axis_tdata[tep_pkg::OUT_BITS-1:0];
        if (expected_results.size() == 0) begin
          report_mismatch("result with none pending", int'(got), 0);
        end else begin
          exp_r = expected_results.pop_front();
          if (got.write_valid !== exp_r.write_valid)
            report_mismatch("write_valid", int'(got.write_valid), int'(exp_r.write_valid));
          if (got.write_row !== exp_r.write_row)
            report_mismatch("write_row", int'(got.write_row), int'(exp_r.write_row));
          if (got.write_col !== exp_r.write_col)
            report_mismatch("write_col", int'(got.write_col), int'(exp_r.write_col));
          if (got.write_char !== exp_r.write_char)
            report_mismatch("write_char", int'(got.write_char), int'(exp_r.write_char));
          if (got.cursor_row_out !== exp_r.cursor_row_out)
            report_mismatch("cursor_row_out", int'(got.cursor_row_out),
                            int'(exp_r.cursor_row_out));
          if (got.cursor_col_out !== exp_r.cursor_col_out)
            report_mismatch("cursor_col_out", int'(got.cursor_col_out),
                            int'(exp_r.cursor_col_out));
          if (got.paste_mode !== exp_r.paste_mode)
            report_mismatch("paste_mode", int'(got.paste_mode), int'(exp_r.paste_mode));
          if (m_axis_tdata[tep_pkg::OUT_BYTES_W-1:tep_pkg::OUT_BITS] !== '0)
            report_mismatch("tdata padding",
                            int'(m_axis_tdata[tep_pkg::OUT_BYTES_W-1:tep_pkg::OUT_BITS]), 0);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("no request accepted for %0d cycles", IDLE_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule
